[hw/rtl/nearest_grid_point_search_defines.svh]
// assertion macros for the nearest grid point search block
// used by ngp_scan, ngp_best and nearest_grid_point_search; needs clk and rst_n in scope
`ifndef NEAREST_GRID_POINT_SEARCH_DEFINES_SVH
`define NEAREST_GRID_POINT_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define NGP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define NGP_ASSERT_RESET(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NGP_ASSERT(label, prop, msg)
`define NGP_ASSERT_RESET(label, prop, msg)
`endif
`endif

[hw/rtl/ngp_pkg.sv]
// shared widths, register codes and pipeline tag type of the nearest grid point search
// no dependencies
`timescale 1ns / 1ps

package ngp_pkg;

    localparam int MAX_ROWS    = 128;
    localparam int MAX_COLS    = 128;
    localparam int LEVEL_LIMIT = 8;

    localparam int COORD_W     = 24;
    localparam int SPACING_W   = 16;
    localparam int ROWS_REG_W  = 8;
    localparam int COLS_REG_W  = 8;
    localparam int LVLS_REG_W  = 4;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int IDX_W       = 17;
    localparam int CLAMP_W     = 16;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LVL_W = (LEVEL_LIMIT > 1) ? $clog2(LEVEL_LIMIT) : 1;

    localparam int ROW_DIM_W = $clog2(MAX_ROWS + 1);
    localparam int COL_DIM_W = $clog2(MAX_COLS + 1);
    localparam int LVL_DIM_W = $clog2(LEVEL_LIMIT + 1);

    localparam int PXY_W  = ((ROW_W > COL_W) ? ROW_W : COL_W) + SPACING_W;
    localparam int PZ_W   = ((COORD_W > LVL_W + SPACING_W) ? COORD_W : LVL_W + SPACING_W) + 1;
    localparam int DIFF_T = (COORD_W > PXY_W + 1) ? COORD_W : PXY_W + 1;
    localparam int DIFF_W = ((DIFF_T > PZ_W) ? DIFF_T : PZ_W) + 1;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int D2_W   = SQ_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS     = 3'd0,
        CFG_GRID_COLS     = 3'd1,
        CFG_GRID_LEVELS   = 3'd2,
        CFG_POINT_SPACING = 3'd3,
        CFG_LEVEL_SPACING = 3'd4,
        CFG_LOWEST_LEVEL  = 3'd5
    } ngp_cfg_idx_t;

    typedef struct packed {
        logic             pt;
        logic             first;
        logic             last;
        logic             empty;
        logic [IDX_W-1:0] idx;
    } ngp_tag_t;

endpackage

[hw/rtl/ngp_scan.sv]
// grid scan counters: one grid point per cycle in level, row, column order
// depends on ngp_pkg and nearest_grid_point_search_defines.svh
`timescale 1ns / 1ps
`include "nearest_grid_point_search_defines.svh"

module ngp_scan
    import ngp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [ROW_DIM_W-1:0]      rows,
    input  logic [COL_DIM_W-1:0]      cols,
    input  logic [LVL_DIM_W-1:0]      levels,
    input  logic [SPACING_W-1:0]      point_spacing,
    input  logic [SPACING_W-1:0]      level_spacing,
    input  logic signed [COORD_W-1:0] lowest_level,
    output ngp_tag_t                  tag,
    output logic [PXY_W-1:0]          px,
    output logic [PXY_W-1:0]          py,
    output logic signed [PZ_W-1:0]    pz
);

    logic                   active_reg, active_next;
    logic                   empty_reg, empty_next;
    logic                   first_reg, first_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [PXY_W-1:0]       px_reg, px_next;
    logic [PXY_W-1:0]       py_reg, py_next;
    logic signed [PZ_W-1:0] pz_reg, pz_next;
    logic                   col_last;
    logic                   row_last;
    logic                   lvl_last;
    logic                   grid_empty;

    assign col_last   = (COL_DIM_W'(col_reg) == cols - COL_DIM_W'(1));
    assign row_last   = (ROW_DIM_W'(row_reg) == rows - ROW_DIM_W'(1));
    assign lvl_last   = (LVL_DIM_W'(lvl_reg) == levels - LVL_DIM_W'(1));
    assign grid_empty = (rows == '0) || (cols == '0) || (levels == '0);

    always_comb
    begin
        active_next = active_reg;
        empty_next  = 1'b0;
        first_next  = 1'b0;
        col_next    = col_reg;
        row_next    = row_reg;
        lvl_next    = lvl_reg;
        idx_next    = idx_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pz_next     = pz_reg;
        if (go)
        begin
            if (grid_empty)
            begin
                empty_next = 1'b1;
            end
            else
            begin
                active_next = 1'b1;
                first_next  = 1'b1;
                col_next    = '0;
                row_next    = '0;
                lvl_next    = '0;
                idx_next    = '0;
                px_next     = '0;
                py_next     = '0;
                pz_next     = PZ_W'(lowest_level);
            end
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (col_last && row_last && lvl_last)
            begin
                active_next = 1'b0;
            end
            if (col_last)
            begin
                col_next = '0;
                px_next  = '0;
                if (row_last)
                begin
                    row_next = '0;
                    py_next  = '0;
                    lvl_next = lvl_reg + LVL_W'(1);
                    pz_next  = pz_reg + $signed(PZ_W'(level_spacing));
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    py_next  = py_reg + PXY_W'(point_spacing);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                px_next  = px_reg + PXY_W'(point_spacing);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            empty_reg  <= 1'b0;
            first_reg  <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            lvl_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            empty_reg  <= empty_next;
            first_reg  <= first_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            lvl_reg    <= lvl_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        pz_reg <= pz_next;
    end

    assign tag.pt    = active_reg;
    assign tag.first = first_reg;
    assign tag.last  = (active_reg && col_last && row_last && lvl_last) || empty_reg;
    assign tag.empty = empty_reg;
    assign tag.idx   = idx_reg;
    assign px        = px_reg;
    assign py        = py_reg;
    assign pz        = pz_reg;

    `NGP_ASSERT(a_scan_one_source, !(active_reg && empty_reg), "scan and empty beat overlap")
    `NGP_ASSERT(a_scan_col_range, active_reg |-> (COL_DIM_W'(col_reg) < cols), "column out of range")
    `NGP_ASSERT(a_scan_first_once, first_reg |=> !first_reg, "first point flagged twice")

endmodule

[hw/rtl/ngp_dist.sv]
// squared distance pipeline: difference, magnitude, square, sum, one register each
// depends on ngp_pkg
`timescale 1ns / 1ps

module ngp_dist
    import ngp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ngp_tag_t                  tag_in,
    input  logic [PXY_W-1:0]          px,
    input  logic [PXY_W-1:0]          py,
    input  logic signed [PZ_W-1:0]    pz,
    input  logic signed [COORD_W-1:0] qx,
    input  logic signed [COORD_W-1:0] qy,
    input  logic signed [COORD_W-1:0] qz,
    output ngp_tag_t                  tag_out,
    output logic [D2_W-1:0]           d2
);

    ngp_tag_t                 tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, dz_next;
    logic [MAG_W-1:0]         mx_reg, my_reg, mz_reg;
    logic [MAG_W-1:0]         mx_next, my_next, mz_next;
    logic [SQ_W-1:0]          sx_reg, sy_reg, sz_reg;
    logic [SQ_W-1:0]          sx_next, sy_next, sz_next;
    logic [D2_W-1:0]          d2_reg, d2_next;

    always_comb
    begin
        dx_next = DIFF_W'(qx) - $signed(DIFF_W'(px));
        dy_next = DIFF_W'(qy) - $signed(DIFF_W'(py));
        dz_next = DIFF_W'(qz) - DIFF_W'(pz);
        mx_next = dx_reg[DIFF_W-1] ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
        my_next = dy_reg[DIFF_W-1] ? MAG_W'(-dy_reg) : MAG_W'(dy_reg);
        mz_next = dz_reg[DIFF_W-1] ? MAG_W'(-dz_reg) : MAG_W'(dz_reg);
        sx_next = SQ_W'(mx_reg) * SQ_W'(mx_reg);
        sy_next = SQ_W'(my_reg) * SQ_W'(my_reg);
        sz_next = SQ_W'(mz_reg) * SQ_W'(mz_reg);
        d2_next = D2_W'(sx_reg) + D2_W'(sy_reg) + D2_W'(sz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        dz_reg <= dz_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
        mz_reg <= mz_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        sz_reg <= sz_next;
        d2_reg <= d2_next;
    end

    assign tag_out = tag_d_reg;
    assign d2      = d2_reg;

endmodule

[hw/rtl/ngp_best.sv]
// running minimum of squared distance and result registers
// depends on ngp_pkg and nearest_grid_point_search_defines.svh
`timescale 1ns / 1ps
`include "nearest_grid_point_search_defines.svh"

module ngp_best
    import ngp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ngp_tag_t         tag,
    input  logic [D2_W-1:0]  d2,
    output logic             done,
    output logic             found,
    output logic [IDX_W-1:0] point_index
);

    logic [D2_W-1:0]  best_d2_reg, best_d2_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             done_reg;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] point_index_reg, point_index_next;
    logic             take;

    always_comb
    begin
        take             = tag.pt && (tag.first || (d2 < best_d2_reg));
        best_d2_next     = take ? d2 : best_d2_reg;
        best_idx_next    = take ? tag.idx : best_idx_reg;
        found_next       = found_reg;
        point_index_next = point_index_reg;
        if (tag.last)
        begin
            found_next       = !tag.empty;
            point_index_next = tag.empty ? '0 : best_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag.last;
        end
    end

    always_ff @(posedge clk)
    begin
        best_d2_reg     <= best_d2_next;
        best_idx_reg    <= best_idx_next;
        found_reg       <= found_next;
        point_index_reg <= point_index_next;
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign point_index = point_index_reg;

    `NGP_ASSERT(a_best_single_done, done_reg |=> !done_reg, "two results in a row")

endmodule

[hw/rtl/nearest_grid_point_search.sv]
// nearest grid point search top level: configuration registers, query capture, control
// depends on ngp_pkg, ngp_scan, ngp_dist, ngp_best and nearest_grid_point_search_defines.svh
`timescale 1ns / 1ps
`include "nearest_grid_point_search_defines.svh"

// Finds the grid point nearest to a 3D query by scanning every point of the configured grid,
// one point per clock. A query is taken when start is high while busy is low; busy then stays
// high until the result is out. The one-point-per-cycle scan counter feeds the four distance
// pipeline registers, and the result register follows them. done is high for exactly one
// cycle with point_index and found valid in that cycle; the result is held until the next done
// but cannot be delayed, so it must be captured then. Write
// configuration only while busy is low.
module nearest_grid_point_search
    import ngp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] query_x,
    input  logic signed [COORD_W-1:0] query_y,
    input  logic signed [COORD_W-1:0] query_z,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output logic                      done,
    output logic [IDX_W-1:0]          point_index,
    output logic                      found
);

    logic [ROWS_REG_W-1:0]     grid_rows_reg;
    logic [COLS_REG_W-1:0]     grid_cols_reg;
    logic [LVLS_REG_W-1:0]     grid_levels_reg;
    logic [SPACING_W-1:0]      point_spacing_reg;
    logic [SPACING_W-1:0]      level_spacing_reg;
    logic signed [COORD_W-1:0] lowest_level_reg;
    logic signed [COORD_W-1:0] query_x_reg;
    logic signed [COORD_W-1:0] query_y_reg;
    logic signed [COORD_W-1:0] query_z_reg;
    logic                      busy_reg, busy_next;
    logic                      go;
    logic [CLAMP_W-1:0]        rows_wide;
    logic [CLAMP_W-1:0]        cols_wide;
    logic [CLAMP_W-1:0]        lvls_wide;
    logic [ROW_DIM_W-1:0]      rows_eff;
    logic [COL_DIM_W-1:0]      cols_eff;
    logic [LVL_DIM_W-1:0]      lvls_eff;
    ngp_tag_t                  scan_tag;
    ngp_tag_t                  dist_tag;
    logic [PXY_W-1:0]          scan_px;
    logic [PXY_W-1:0]          scan_py;
    logic signed [PZ_W-1:0]    scan_pz;
    logic [D2_W-1:0]           dist_d2;
    logic                      best_done;

    assign go = start && !busy_reg;

    // dimensions above the maximum saturate
    always_comb
    begin
        rows_wide = CLAMP_W'(grid_rows_reg);
        cols_wide = CLAMP_W'(grid_cols_reg);
        lvls_wide = CLAMP_W'(grid_levels_reg);
        rows_eff  = ROW_DIM_W'((rows_wide > CLAMP_W'(MAX_ROWS)) ? CLAMP_W'(MAX_ROWS) : rows_wide);
        cols_eff  = COL_DIM_W'((cols_wide > CLAMP_W'(MAX_COLS)) ? CLAMP_W'(MAX_COLS) : cols_wide);
        lvls_eff  = LVL_DIM_W'((lvls_wide > CLAMP_W'(LEVEL_LIMIT)) ?
                               CLAMP_W'(LEVEL_LIMIT) : lvls_wide);
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (go)
        begin
            busy_next = 1'b1;
        end
        else if (best_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            grid_rows_reg     <= ROWS_REG_W'(1);
            grid_cols_reg     <= COLS_REG_W'(1);
            grid_levels_reg   <= LVLS_REG_W'(1);
            point_spacing_reg <= SPACING_W'(256);
            level_spacing_reg <= SPACING_W'(256);
            lowest_level_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_write)
            begin
                unique case (ngp_cfg_idx_t'(cfg_index))
                    CFG_GRID_ROWS:     grid_rows_reg     <= cfg_data[ROWS_REG_W-1:0];
                    CFG_GRID_COLS:     grid_cols_reg     <= cfg_data[COLS_REG_W-1:0];
                    CFG_GRID_LEVELS:   grid_levels_reg   <= cfg_data[LVLS_REG_W-1:0];
                    CFG_POINT_SPACING: point_spacing_reg <= cfg_data[SPACING_W-1:0];
                    CFG_LEVEL_SPACING: level_spacing_reg <= cfg_data[SPACING_W-1:0];
                    CFG_LOWEST_LEVEL:  lowest_level_reg  <= $signed(cfg_data[COORD_W-1:0]);
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            query_x_reg <= query_x;
            query_y_reg <= query_y;
            query_z_reg <= query_z;
        end
    end

    ngp_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (go),
        .rows          (rows_eff),
        .cols          (cols_eff),
        .levels        (lvls_eff),
        .point_spacing (point_spacing_reg),
        .level_spacing (level_spacing_reg),
        .lowest_level  (lowest_level_reg),
        .tag           (scan_tag),
        .px            (scan_px),
        .py            (scan_py),
        .pz            (scan_pz)
    );

    ngp_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (scan_tag),
        .px      (scan_px),
        .py      (scan_py),
        .pz      (scan_pz),
        .qx      (query_x_reg),
        .qy      (query_y_reg),
        .qz      (query_z_reg),
        .tag_out (dist_tag),
        .d2      (dist_d2)
    );

    ngp_best u_best (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (dist_tag),
        .d2          (dist_d2),
        .done        (best_done),
        .found       (found),
        .point_index (point_index)
    );

    assign busy = busy_reg;
    assign done = best_done;

    `NGP_ASSERT(a_top_done_in_query, best_done |-> busy_reg, "result outside a query")
    `NGP_ASSERT(a_top_empty_index, (best_done && !found) |-> (point_index == '0), "empty grid index")
    `NGP_ASSERT_RESET(a_top_reset_idle, !rst_n |=> !busy_reg, "busy after reset")

endmodule

[test/tb_nearest_grid_point_search.sv]
`timescale 1ns / 1ps
// self-checking testbench for nearest_grid_point_search: directed and random queries over
// many grid settings, each result checked against a brute-force scan done in the testbench
// depends on ngp_pkg and the nearest_grid_point_search rtl

module tb_nearest_grid_point_search;
    import ngp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam longint COORD_HI = 8388607;
    localparam longint COORD_LO = -8388608;
    localparam int MAX_REPORTS = 10;
    localparam int END_DRAIN = 20;
    localparam int RANDOM_PHASES = 8;
    localparam int QUERIES_PER_PHASE = 10;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } query_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             found;
    } nearest_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] query_x = '0;
    logic signed [COORD_W-1:0] query_y = '0;
    logic signed [COORD_W-1:0] query_z = '0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      done;
    logic [IDX_W-1:0]          point_index;
    logic                      found;

    // grid setting the block should hold
    logic [ROWS_REG_W-1:0]     grid_rows_q = 8'd1;
    logic [COLS_REG_W-1:0]     grid_cols_q = 8'd1;
    logic [LVLS_REG_W-1:0]     grid_levels_q = 4'd1;
    logic [SPACING_W-1:0]      point_spacing_q = 16'd256;
    logic [SPACING_W-1:0]      level_spacing_q = 16'd256;
    logic signed [COORD_W-1:0] lowest_level_q = '0;

    query_t   pending_queries[$];
    nearest_t expected_nearest[$];
    nearest_t head_result;
    int       idle_pcts[3] = '{0, 80, 27};
    int       sender_idle_pct = 0;
    int       queries_launched = 0;
    int       results_seen = 0;
    int       empty_results = 0;
    int       settings_applied = 0;
    int       mismatches = 0;

    nearest_grid_point_search DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .query_x     (query_x),
        .query_y     (query_y),
        .query_z     (query_z),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .point_index (point_index),
        .found       (found)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint dim_in_use(input longint v, input longint limit);
        return (v > limit) ? limit : v;
    endfunction

    // exhaustive scan in level, row, column order; strict compare keeps the first on a tie
    function automatic nearest_t nearest_point(input logic signed [COORD_W-1:0] qx, qy, qz);
        longint   nr, nc, nl, lv, r, c;
        longint   pz, py, px, dz, dy, dx;
        longint   best, dz2, dyz2, d2, idx;
        logic     have;
        nearest_t res;
        nr = dim_in_use(longint'(grid_rows_q), longint'(MAX_ROWS));
        nc = dim_in_use(longint'(grid_cols_q), longint'(MAX_COLS));
        nl = dim_in_use(longint'(grid_levels_q), longint'(LEVEL_LIMIT));
        have = 1'b0;
        best = 0;
        res = '0;
        for (lv = 0; lv < nl; lv++)
        begin
            pz = longint'(lowest_level_q) + lv * longint'(level_spacing_q);
            dz = longint'(qz) - pz;
            dz2 = dz * dz;
            for (r = 0; r < nr; r++)
            begin
                py = r * longint'(point_spacing_q);
                dy = longint'(qy) - py;
                dyz2 = dz2 + dy * dy;
                for (c = 0; c < nc; c++)
                begin
                    px = c * longint'(point_spacing_q);
                    dx = longint'(qx) - px;
                    d2 = dyz2 + dx * dx;
                    if (!have || d2 < best)
                    begin
                        have = 1'b1;
                        best = d2;
                        idx = lv * nr * nc + r * nc + c;
                        res.index = idx[IDX_W-1:0];
                    end
                end
            end
        end
        res.found = have;
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(input longint lo, input longint hi);
        longint v;
        v = lo + longint'($urandom_range(32'(hi - lo), 0));
        if (v > COORD_HI)
            v = COORD_HI;
        if (v < COORD_LO)
            v = COORD_LO;
        return v[COORD_W-1:0];
    endfunction

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_nearest.push_back(nearest_point(query_x, query_y, query_z));
            if (!start || !busy)
            begin
                if (pending_queries.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    start <= 1'b1;
                    query_x <= pending_queries[0].x;
                    query_y <= pending_queries[0].y;
                    query_z <= pending_queries[0].z;
                    void'(pending_queries.pop_front());
                    queries_launched++;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_nearest.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: point_index %0d found %0b", point_index, found);
                mismatches++;
            end
            else
            begin
                head_result = expected_nearest.pop_front();
                if (!head_result.found)
                    empty_results++;
                if (point_index !== head_result.index || found !== head_result.found)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("result %0d: expected point_index %0d found %0b, got %0d %0b",
                                 results_seen, head_result.index, head_result.found,
                                 point_index, found);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_GRID_ROWS:     grid_rows_q = data[ROWS_REG_W-1:0];
            CFG_GRID_COLS:     grid_cols_q = data[COLS_REG_W-1:0];
            CFG_GRID_LEVELS:   grid_levels_q = data[LVLS_REG_W-1:0];
            CFG_POINT_SPACING: point_spacing_q = data[SPACING_W-1:0];
            CFG_LEVEL_SPACING: level_spacing_q = data[SPACING_W-1:0];
            CFG_LOWEST_LEVEL:  lowest_level_q = data[COORD_W-1:0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    // unused upper data bits carry junk
    task automatic apply_grid(input int rows, cols, levels, spacing, lvl_spacing, lowest,
                              input int idle_pct);
        int junk;
        junk = $urandom();
        @(posedge clk);
        write_reg(CFG_GRID_ROWS, {junk[15:0], rows[ROWS_REG_W-1:0]});
        write_reg(CFG_GRID_COLS, {junk[23:8], cols[COLS_REG_W-1:0]});
        write_reg(CFG_GRID_LEVELS, {junk[19:0], levels[LVLS_REG_W-1:0]});
        write_reg(CFG_POINT_SPACING, {junk[7:0], spacing[SPACING_W-1:0]});
        write_reg(CFG_LEVEL_SPACING, {junk[15:8], lvl_spacing[SPACING_W-1:0]});
        write_reg(CFG_LOWEST_LEVEL, lowest[CFG_DATA_W-1:0]);
        write_reg(CFG_SPARE_A, junk[23:0]);
        write_reg(CFG_SPARE_B, junk[31:8]);
        cfg_write <= 1'b0;
        settings_applied++;
        sender_idle_pct = idle_pct;
    endtask

    task automatic add_query(input int x, y, z);
        query_t q;
        q.x = x[COORD_W-1:0];
        q.y = y[COORD_W-1:0];
        q.z = z[COORD_W-1:0];
        pending_queries.push_back(q);
    endtask

    // mostly near the grid, some on half-spacing points to force ties, some anywhere
    task automatic add_random_queries(input int count);
        longint nr, nc, nl, step, lstep, lo_z, k;
        int     mode;
        query_t q;
        nr = dim_in_use(longint'(grid_rows_q), longint'(MAX_ROWS));
        nc = dim_in_use(longint'(grid_cols_q), longint'(MAX_COLS));
        nl = dim_in_use(longint'(grid_levels_q), longint'(LEVEL_LIMIT));
        step = longint'(point_spacing_q);
        lstep = longint'(level_spacing_q);
        lo_z = longint'(lowest_level_q);
        for (int i = 0; i < count; i++)
        begin
            mode = int'($urandom_range(9));
            if (mode < 2)
            begin
                q.x = COORD_W'($urandom());
                q.y = COORD_W'($urandom());
                q.z = COORD_W'($urandom());
            end
            else if (mode < 4)
            begin
                k = longint'($urandom_range(32'(2 * nc), 0));
                q.x = near_coord(k * step / 2, k * step / 2);
                k = longint'($urandom_range(32'(2 * nr), 0));
                q.y = near_coord(k * step / 2, k * step / 2);
                k = longint'($urandom_range(32'(2 * nl), 0));
                q.z = near_coord(lo_z + k * lstep / 2, lo_z + k * lstep / 2);
            end
            else
            begin
                q.x = near_coord(-step, nc * step);
                q.y = near_coord(-step, nr * step);
                q.z = near_coord(lo_z - lstep, lo_z + nl * lstep);
            end
            pending_queries.push_back(q);
        end
    endtask

    task automatic drain;
        while (pending_queries.size() != 0 || results_seen < queries_launched)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        int rows, cols, levels, spacing, lvl_spacing, lowest;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid: a single point at the origin
        add_query(8388607, 8388607, 8388607);
        add_query(-8388608, -8388608, -8388608);
        add_query(0, 0, 0);
        drain;

        apply_grid(4, 5, 3, 256, 512, -256, 0);
        add_query(0, 0, -256);
        add_query(1024, 768, 768);
        add_query(128, 0, -256);
        add_query(6024, -5000, 100000);
        add_query(-8388608, 8388607, -8388608);
        add_query(8388607, -8388608, 8388607);
        add_query(640, 384, 0);
        add_query(300, 500, 500);
        drain;

        // empty grids
        apply_grid(0, 5, 2, 256, 256, 0, 0);
        add_query(0, 0, 0);
        add_query(-1, 8388607, -8388608);
        drain;
        apply_grid(3, 0, 2, 256, 256, 0, 0);
        add_query(100, 100, 100);
        drain;
        apply_grid(3, 3, 0, 256, 256, 0, 0);
        add_query(100, 100, 100);
        drain;

        // zero spacing: every point coincides, the first one wins
        apply_grid(3, 3, 2, 0, 0, 1234, 27);
        add_query(500, -500, 0);
        add_query(-8388608, 8388607, 1234);
        drain;

        apply_grid(2, 3, 2, 65535, 65535, 8388607, 0);
        add_query(8388607, 8388607, 8388607);
        add_query(0, 0, -8388608);
        drain;

        // oversized dimensions saturate to the full grid
        apply_grid(255, 129, 15, 65535, 65535, -8388608, 0);
        add_query(8388607, 8388607, 8388607);
        add_query(-8388608, 0, 0);
        drain;
        apply_grid(128, 128, 8, 300, 1000, 0, 0);
        add_query(20000, 30000, 3500);
        drain;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            rows = ($urandom_range(15) == 0) ? 0 : int'($urandom_range(10, 1));
            cols = ($urandom_range(15) == 0) ? 0 : int'($urandom_range(10, 1));
            levels = ($urandom_range(15) == 0) ? 0 : int'($urandom_range(15, 1));
            spacing = $urandom_range(1) ? int'($urandom_range(700, 0))
                                        : int'($urandom_range(65535, 0));
            lvl_spacing = $urandom_range(1) ? int'($urandom_range(700, 0))
                                            : int'($urandom_range(65535, 0));
            lowest = $urandom_range(1) ? int'($urandom_range(2000, 0)) - 1000
                                       : int'($urandom_range(32'hFFFFFF, 0)) - 8388608;
            apply_grid(rows, cols, levels, spacing, lvl_spacing, lowest, idle_pcts[p % 3]);
            add_random_queries(QUERIES_PER_PHASE);
            drain;
        end

        repeat (END_DRAIN) @(posedge clk);
        if (expected_nearest.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_nearest.size());
            mismatches += expected_nearest.size();
        end
        $display("checked %0d query results over %0d grid settings, %0d of them on empty grids",
                 results_seen, settings_applied, empty_results);
        $display("%0d mismatching or missing results", mismatches);
        if (mismatches == 0)
            $display("nearest_grid_point_search: match");
        else
            $display("nearest_grid_point_search: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("nearest_grid_point_search: mismatch");
        $finish;
    end

endmodule
